### hw/rtl/bgd_pkg.sv
// Shared types, opcodes, screen geometry and scaling constants for the
// bar-graph draw core. No dependencies; every other file imports this one.
package bgd_pkg;

    // Draw command opcodes
    localparam logic [1:0] OP_ERASE = 2'd0;
    localparam logic [1:0] OP_BOX   = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // Commands a single sample can cause: clear, fill change, four markers
    localparam int NUM_SLOTS = 6;

    // Vertical bar geometry
    localparam logic [8:0] V_CAP       = 9'd190;
    localparam logic [9:0] V_BASE_ROW  = 10'd225;
    localparam logic [8:0] V_COLUMN    = 9'd162;
    localparam logic [8:0] V_SPAN      = 9'd9;
    localparam logic [7:0] V_CLR_ROW   = 8'd34;
    localparam logic [8:0] V_CLR_HGT   = 9'd190;

    // Horizontal bar geometry
    localparam logic [8:0] H_CAP       = 9'd306;
    localparam logic [7:0] H_ROW       = 8'd199;
    localparam logic [8:0] H_HEIGHT    = 9'd13;
    localparam logic [9:0] H_BASE_COL  = 10'd2;
    localparam logic [8:0] H_CLR_COL   = 9'd3;
    localparam logic [8:0] H_CLR_SPAN  = 9'd313;

    // Input clamps: beyond these the scaled level saturates at the cap
    localparam logic [9:0] V_RAW_MAX   = 10'd950;
    localparam logic [9:0] H_RAW_MAX   = 10'd900;
    localparam logic [9:0] V_MARK_MAX  = 10'd95;
    localparam logic [9:0] H_MARK_MAX  = 10'd90;

    // Reciprocals: x/5 = (x*13108)>>16 for x < 16384, x/50 = (x*20972)>>20
    // for x < 43690; both ranges cover the clamped operands.
    localparam logic [13:0] RECIP_5    = 14'd13108;
    localparam logic [14:0] RECIP_50   = 15'd20972;

    // Scaled levels of one sample, in pixels, with its orientation
    typedef struct packed {
        logic       horiz;
        logic [8:0] fill;
        logic [8:0] peak;
        logic [8:0] peep;
    } level_t;

    // One draw command
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] row;
        logic [8:0] column;
        logic [8:0] height;
        logic [8:0] span;
        logic       ink;
    } cmd_t;

endpackage

### hw/rtl/incremental_bargraph_draw_core.sv
// Bar-graph draw core: each pressure sample request yields between zero and six
// draw commands (interior clear, fill box or erase, old and new peak and PEEP
// marker lines), sent one per cycle while the output is not stalled, with the
// last command of the sample flagged. The first command is offered once the
// sample has passed the input holding register and the output slot registers,
// if the slots are free. A sample with at most one command frees them once that
// command is taken, so such samples stream at one per cycle unless the output
// stalls; otherwise a sample holds the single output port until its commands,
// up to six, are sent, while the next sample waits already scaled in the input
// stage. The user must write orientation only while no sample is in flight;
// the block does not enforce this. Depends on bgd_pkg, bgd_scale and bgd_build.
module incremental_bargraph_draw_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] pressure,
    input  logic [9:0]         peak_level,
    input  logic [9:0]         peep_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         op,
    output logic [7:0]         row,
    output logic [8:0]         column,
    output logic [8:0]         height,
    output logic [8:0]         span,
    output logic               ink,
    output logic               last
);
    import bgd_pkg::*;

    logic   orient_reg;
    logic   lvl_valid;
    logic   lvl_take;
    level_t lvl;
    cmd_t   cmd;

    // Orientation register: 0 vertical, 1 horizontal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            orient_reg <= cfg_data;
        end
    end

    // Clamp and scale stage
    bgd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pressure   (pressure),
        .peak_level (peak_level),
        .peep_level (peep_level),
        .horiz      (orient_reg),
        .lvl_valid  (lvl_valid),
        .lvl_take   (lvl_take),
        .lvl        (lvl)
    );

    // Command generation and output slots
    bgd_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .lvl       (lvl),
        .lvl_valid (lvl_valid),
        .lvl_take  (lvl_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .last      (last)
    );

    assign op     = cmd.op;
    assign row    = cmd.row;
    assign column = cmd.column;
    assign height = cmd.height;
    assign span   = cmd.span;
    assign ink    = cmd.ink;

endmodule

### hw/rtl/bgd_scale.sv
// Input stage of the bar-graph draw core: takes a sample request, clamps and
// scales it to pixel levels, and holds the result. Depends on bgd_pkg.
module bgd_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  pressure,
    input  logic [9:0]          peak_level,
    input  logic [9:0]          peep_level,
    input  logic                horiz,
    output logic                lvl_valid,
    input  logic                lvl_take,
    output bgd_pkg::level_t     lvl
);
    import bgd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    level_t      lvl_reg;
    level_t      lvl_next;
    logic        accept;
    logic [14:0] raw;
    logic [9:0]  raw_v;
    logic [9:0]  raw_h;
    logic [23:0] prod_v;
    logic [13:0] mul17_h;
    logic [28:0] prod_h;

    // Scale a marker level: twice the level vertically, level*306/90
    // horizontally, both saturating at the cap.
    function automatic logic [8:0] scale_marker(input logic hz, input logic [9:0] m);
        logic [9:0]  mc;
        logic [10:0] x17;
        logic [24:0] prod;
        logic [8:0]  res;
        if (hz)
        begin
            mc   = (m > H_MARK_MAX) ? H_MARK_MAX : m;
            x17  = {mc[6:0], 4'd0} + {4'd0, mc[6:0]};
            prod = 25'(x17) * 25'(RECIP_5);
            res  = prod[24:16];
        end
        else
        begin
            mc   = (m > V_MARK_MAX) ? V_MARK_MAX : m;
            x17  = '0;
            prod = '0;
            res  = {1'b0, mc[6:0], 1'b0};
        end
        return res;
    endfunction

    // Negative samples count as zero, then clamp to the saturation point
    assign raw   = pressure[15] ? 15'd0 : pressure[14:0];
    assign raw_v = (raw > {5'd0, V_RAW_MAX}) ? V_RAW_MAX : raw[9:0];
    assign raw_h = (raw > {5'd0, H_RAW_MAX}) ? H_RAW_MAX : raw[9:0];

    // Fill level: raw/5 vertically, raw*17/50 horizontally
    assign prod_v  = 24'(raw_v) * 24'(RECIP_5);
    assign mul17_h = {raw_h, 4'd0} + {4'd0, raw_h};
    assign prod_h  = 29'(mul17_h) * 29'(RECIP_50);

    always_comb
    begin
        lvl_next.horiz = horiz;
        lvl_next.fill  = horiz ? prod_h[28:20] : {1'b0, prod_v[23:16]};
        lvl_next.peak  = scale_marker(horiz, peak_level);
        lvl_next.peep  = scale_marker(horiz, peep_level);
    end

    // Holding register handshake
    assign in_stall   = valid_reg && !lvl_take;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (lvl_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lvl_reg <= lvl_next;
        end
    end

    assign lvl_valid = valid_reg;
    assign lvl      = lvl_reg;

endmodule

### hw/rtl/bgd_build.sv
// Command stage of the bar-graph draw core: compares new levels with the shown
// ones, loads up to six commands into slot registers and sends them one per
// cycle while the output is not stalled. Depends on bgd_pkg.
module bgd_build (
    input  logic            clk,
    input  logic            rst_n,
    input  bgd_pkg::level_t lvl,
    input  logic            lvl_valid,
    output logic            lvl_take,
    output logic            out_valid,
    input  logic            out_stall,
    output bgd_pkg::cmd_t   cmd,
    output logic            last
);
    import bgd_pkg::*;

    logic [8:0]           fill_reg, fill_next;
    logic [8:0]           peak_reg, peak_next;
    logic [8:0]           peep_reg, peep_next;
    logic                 vready_reg, vready_next;
    logic                 hready_reg, hready_next;
    logic [NUM_SLOTS-1:0] pending_reg, pending_next;
    cmd_t                 slot_reg [NUM_SLOTS];
    cmd_t                 cand [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] present;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] remain;
    logic                 clear;
    logic [8:0]           m;
    logic [8:0]           old_peak;
    logic [8:0]           old_peep;
    logic [8:0]           v;
    logic [8:0]           dv;
    logic [8:0]           dm;
    logic [8:0]           up_ext;
    logic [8:0]           down_ext;
    logic [9:0]           up_pos;
    logic [9:0]           down_pos;
    logic                 out_accept;

    // Marker line at a given level
    function automatic cmd_t marker_cmd(input logic hz, input logic [8:0] lv,
                                        input logic ink);
        cmd_t c;
        logic [9:0] pos;
        c.op  = OP_LINE;
        c.ink = ink;
        if (hz)
        begin
            pos      = H_BASE_COL + {1'b0, lv};
            c.row    = H_ROW;
            c.column = pos[8:0];
            c.height = H_HEIGHT;
            c.span   = 9'd0;
        end
        else
        begin
            pos      = V_BASE_ROW - {1'b0, lv};
            c.row    = pos[7:0];
            c.column = V_COLUMN;
            c.height = 9'd0;
            c.span   = V_SPAN;
        end
        return c;
    endfunction

    // Levels as they stand on screen; a clear of the interior resets them
    assign clear    = lvl.horiz ? !hready_reg : !vready_reg;
    assign m        = clear ? 9'd0 : fill_reg;
    assign old_peak = clear ? 9'd0 : peak_reg;
    assign old_peep = clear ? 9'd0 : peep_reg;
    assign v        = lvl.fill;

    // A zero fill level counts one pixel further out
    assign dv       = (v == 9'd0) ? 9'd1 : 9'd0;
    assign dm       = (m == 9'd0) ? 9'd1 : 9'd0;
    assign up_ext   = v - dm - m;
    assign down_ext = m - dv - v;
    assign up_pos   = lvl.horiz ? (H_BASE_COL + {1'b0, dm + m}) : (V_BASE_ROW - {1'b0, v});
    assign down_pos = lvl.horiz ? (H_BASE_COL + {1'b0, dv + v}) : (V_BASE_ROW - {1'b0, m});

    // Candidate commands in their fixed order
    always_comb
    begin
        // Interior clear
        if (lvl.horiz)
        begin
            cand[0] = '{op: OP_ERASE, row: H_ROW, column: H_CLR_COL,
                        height: H_HEIGHT, span: H_CLR_SPAN, ink: 1'b0};
        end
        else
        begin
            cand[0] = '{op: OP_ERASE, row: V_CLR_ROW, column: V_COLUMN,
                        height: V_CLR_HGT, span: V_SPAN, ink: 1'b0};
        end

        // Fill change: a box over the gained part or an erase of the lost part
        cand[1].op  = (v > m) ? OP_BOX : OP_ERASE;
        cand[1].ink = (v > m);
        if (lvl.horiz)
        begin
            cand[1].row    = H_ROW;
            cand[1].column = (v > m) ? up_pos[8:0] : down_pos[8:0];
            cand[1].height = H_HEIGHT;
            cand[1].span   = (v > m) ? up_ext : down_ext;
        end
        else
        begin
            cand[1].row    = (v > m) ? up_pos[7:0] : down_pos[7:0];
            cand[1].column = V_COLUMN;
            cand[1].height = (v > m) ? up_ext : down_ext;
            cand[1].span   = V_SPAN;
        end

        // Old markers are inked when covered by the new fill, new ones cleared
        cand[2] = marker_cmd(lvl.horiz, old_peak, old_peak < v);
        cand[3] = marker_cmd(lvl.horiz, lvl.peak, !(lvl.peak < v));
        cand[4] = marker_cmd(lvl.horiz, old_peep, old_peep < v);
        cand[5] = marker_cmd(lvl.horiz, lvl.peep, !(lvl.peep < v));

        present[0] = clear;
        present[1] = (v != m);
        present[2] = (old_peak != 9'd0);
        present[3] = (lvl.peak != 9'd0);
        present[4] = (old_peep != 9'd0);
        present[5] = (lvl.peep != 9'd0);
    end

    // Send the lowest pending slot; the slots free up when the last one leaves
    assign sel        = pending_reg & (~pending_reg + NUM_SLOTS'(1));
    assign out_valid  = |pending_reg;
    assign last       = ((pending_reg & ~sel) == '0);
    assign out_accept = out_valid && !out_stall;
    assign remain     = out_accept ? (pending_reg & ~sel) : pending_reg;
    assign lvl_take   = lvl_valid && (remain == '0);

    always_comb
    begin
        cmd = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (sel[i])
            begin
                cmd = cmd | slot_reg[i];
            end
        end
    end

    // Shown levels and ready flags follow each sample taken
    always_comb
    begin
        pending_next = remain;
        fill_next    = fill_reg;
        peak_next    = peak_reg;
        peep_next    = peep_reg;
        vready_next  = vready_reg;
        hready_next  = hready_reg;
        if (lvl_take)
        begin
            pending_next = present;
            fill_next    = v;
            peak_next    = lvl.peak;
            peep_next    = lvl.peep;
            if (clear)
            begin
                vready_next = !lvl.horiz;
                hready_next = lvl.horiz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            fill_reg    <= '0;
            peak_reg    <= '0;
            peep_reg    <= '0;
            vready_reg  <= 1'b0;
            hready_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
            peak_reg    <= peak_next;
            peep_reg    <= peep_next;
            vready_reg  <= vready_next;
            hready_reg  <= hready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lvl_take)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= cand[i];
            end
        end
    end

endmodule

### hw/rtl/bgd_checker.sv
// Port-level checks for the bar-graph draw core, and the bind that attaches
// them to incremental_bargraph_draw_core. Depends on bgd_pkg.
module bgd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] op,
    input logic [7:0] row,
    input logic [8:0] column,
    input logic [8:0] height,
    input logic [8:0] span,
    input logic       ink,
    input logic       last
);
    import bgd_pkg::*;

    // A stalled command request stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    // A stalled command does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(op) && $stable(row) && $stable(column)
            && $stable(height) && $stable(span) && $stable(ink) && $stable(last))
        else $error("output command changed while stalled");

    // An erase always clears pixels
    a_erase_ink: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op == OP_ERASE) |-> !ink)
        else $error("erase command with ink set");

    // A marker line is flat in one direction
    a_line_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op == OP_LINE) |-> (height == 9'd0) || (span == 9'd0))
        else $error("marker line with two nonzero extents");

endmodule

bind incremental_bargraph_draw_core bgd_checker u_bgd_checker (.*);

### bench/incremental_bargraph_draw_core_tb.sv
// Self-checking bench for the bar-graph draw core: drives pressure sample requests,
// predicts the draw commands of each accepted sample and compares them in order.
// Depends on bgd_pkg and incremental_bargraph_draw_core.
module incremental_bargraph_draw_core_tb;

    import bgd_pkg::*;

    // Orientation register values
    localparam logic ORIENT_VERT  = 1'b0;
    localparam logic ORIENT_HORIZ = 1'b1;

    // Screen geometry of both bars
    localparam int unsigned VERT_LIMIT     = 190;
    localparam int unsigned VERT_FLOOR_ROW = 225;
    localparam int unsigned VERT_COL       = 162;
    localparam int unsigned VERT_SPAN      = 9;
    localparam int unsigned VERT_WIPE_ROW  = 34;
    localparam int unsigned VERT_WIPE_HGT  = 190;
    localparam int unsigned HORZ_LIMIT     = 306;
    localparam int unsigned HORZ_ROW       = 199;
    localparam int unsigned HORZ_HGT       = 13;
    localparam int unsigned HORZ_BASE_COL  = 2;
    localparam int unsigned HORZ_WIPE_COL  = 3;
    localparam int unsigned HORZ_WIPE_SPAN = 313;

    // Run control
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          PHASE_SAMPLES  = 44;
    localparam int          NUM_PHASES     = 8;
    localparam logic [7:0]  ORIENT_PLAN    = 8'b01101100;

    typedef struct packed {
        logic signed [15:0] pressure;
        logic [9:0]         peak;
        logic [9:0]         peep;
    } sample_t;

    typedef struct packed {
        cmd_t cmd;
        logic last;
    } due_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] pressure = '0;
    logic [9:0]         peak_level = '0;
    logic [9:0]         peep_level = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         op;
    logic [7:0]         row;
    logic [8:0]         column;
    logic [8:0]         height;
    logic [8:0]         span;
    logic               ink;
    logic               last;

    incremental_bargraph_draw_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pressure   (pressure),
        .peak_level (peak_level),
        .peep_level (peep_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .op         (op),
        .row        (row),
        .column     (column),
        .height     (height),
        .span       (span),
        .ink        (ink),
        .last       (last)
    );

    // Pending requests, expected commands and the shadow copy of the block state
    sample_t     samples_pending [$];
    due_cmd_t    draw_cmds_due [$];
    sample_t     offered;
    due_cmd_t    oldest_due;
    logic        orientation = ORIENT_VERT;
    logic [8:0]  bar_fill = '0;
    logic [8:0]  bar_peak = '0;
    logic [8:0]  bar_peep = '0;
    logic        vert_cleared = 1'b0;
    logic        horiz_cleared = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic        hold_phase = 1'b0;
    int          hold_cnt = 0;
    logic signed [15:0] prev_pressure = '0;
    wire         holding = hold_phase && (hold_cnt < HOLD_CYCLES);

    always #5 clk = ~clk;

    function automatic cmd_t make_cmd(logic [1:0] code, int unsigned r, int unsigned col,
                                      int unsigned hgt, int unsigned wid, logic color);
        cmd_t c;
        c.op     = code;
        c.row    = 8'(r);
        c.column = 9'(col);
        c.height = 9'(hgt);
        c.span   = 9'(wid);
        c.ink    = color;
        return c;
    endfunction

    // A marker is a flat line across the bar at its level.
    function automatic cmd_t marker_cmd(logic vert, int unsigned lvl, logic color);
        if (vert)
            return make_cmd(OP_LINE, VERT_FLOOR_ROW - lvl, VERT_COL, 0, VERT_SPAN, color);
        return make_cmd(OP_LINE, HORZ_ROW, HORZ_BASE_COL + lvl, HORZ_HGT, 0, color);
    endfunction

    // Scale one sample, work out the commands that bring the bar up to date and
    // queue them with the final one flagged.
    task automatic compute_draw_cmds(input sample_t s);
        int unsigned raw, lvl, pk, pp, cap, m, dv, dm, ext;
        logic        vert;
        int          n, k;
        cmd_t        cmds [NUM_SLOTS];
        due_cmd_t    e;
        raw  = s.pressure[15] ? 0 : int'(s.pressure[14:0]);
        vert = (orientation == ORIENT_VERT);
        if (vert)
        begin
            lvl = raw / 5;
            pk  = s.peak * 2;
            pp  = s.peep * 2;
            cap = VERT_LIMIT;
        end
        else
        begin
            lvl = (raw * 306) / 900;
            pk  = (s.peak * 306) / 90;
            pp  = (s.peep * 306) / 90;
            cap = HORZ_LIMIT;
        end
        if (lvl > cap) lvl = cap;
        if (pk > cap) pk = cap;
        if (pp > cap) pp = cap;
        n = 0;

        // First sample in an orientation wipes the interior.
        if (vert && !vert_cleared)
        begin
            cmds[n] = make_cmd(OP_ERASE, VERT_WIPE_ROW, VERT_COL, VERT_WIPE_HGT,
                               VERT_SPAN, 1'b0);
            n++;
            bar_fill = '0;
            bar_peak = '0;
            bar_peep = '0;
            horiz_cleared = 1'b0;
            vert_cleared  = 1'b1;
        end
        else if (!vert && !horiz_cleared)
        begin
            cmds[n] = make_cmd(OP_ERASE, HORZ_ROW, HORZ_WIPE_COL, HORZ_HGT,
                               HORZ_WIPE_SPAN, 1'b0);
            n++;
            bar_fill = '0;
            bar_peak = '0;
            bar_peep = '0;
            vert_cleared  = 1'b0;
            horiz_cleared = 1'b1;
        end

        // Fill change; a zero level counts as one pixel further out.
        m  = bar_fill;
        dv = (lvl == 0) ? 1 : 0;
        dm = (m == 0) ? 1 : 0;
        if (lvl > m)
        begin
            ext = dv + lvl - dm - m;
            if (vert)
                cmds[n] = make_cmd(OP_BOX, VERT_FLOOR_ROW - dv - lvl, VERT_COL, ext,
                                   VERT_SPAN, 1'b1);
            else
                cmds[n] = make_cmd(OP_BOX, HORZ_ROW, HORZ_BASE_COL + dm + m, HORZ_HGT,
                                   ext, 1'b1);
            n++;
        end
        else if (lvl < m)
        begin
            ext = dm + m - dv - lvl;
            if (vert)
                cmds[n] = make_cmd(OP_ERASE, VERT_FLOOR_ROW - dm - m, VERT_COL, ext,
                                   VERT_SPAN, 1'b0);
            else
                cmds[n] = make_cmd(OP_ERASE, HORZ_ROW, HORZ_BASE_COL + dv + lvl, HORZ_HGT,
                                   ext, 1'b0);
            n++;
        end

        // Old markers are redrawn to undo them, new ones drawn against the new fill.
        if (bar_peak != 0)
        begin
            cmds[n] = marker_cmd(vert, bar_peak, bar_peak < lvl);
            n++;
        end
        if (pk != 0)
        begin
            cmds[n] = marker_cmd(vert, pk, !(pk < lvl));
            n++;
        end
        if (bar_peep != 0)
        begin
            cmds[n] = marker_cmd(vert, bar_peep, bar_peep < lvl);
            n++;
        end
        if (pp != 0)
        begin
            cmds[n] = marker_cmd(vert, pp, !(pp < lvl));
            n++;
        end
        bar_fill = 9'(lvl);
        bar_peak = 9'(pk);
        bar_peep = 9'(pp);

        for (k = 0; k < n; k++)
        begin
            e.cmd  = cmds[k];
            e.last = (k == n - 1);
            draw_cmds_due.push_back(e);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Random sample: mostly in the working range, with repeats, negatives and
    // the occasional fully random field.
    function automatic sample_t gen_sample();
        sample_t s;
        int      r;
        r = $urandom_range(99);
        if (r < 8)
            s.pressure = 16'($urandom);
        else if (r < 14)
            s.pressure = 16'(-int'($urandom_range(200, 1)));
        else if (r < 22)
            s.pressure = prev_pressure;
        else if (r < 28)
            s.pressure = 16'($urandom_range(10));
        else
            s.pressure = 16'($urandom_range(1000));
        r = $urandom_range(99);
        s.peak = (r < 10) ? 10'($urandom) : (r < 25) ? 10'd0 : 10'($urandom_range(100));
        r = $urandom_range(99);
        s.peep = (r < 10) ? 10'($urandom) : (r < 25) ? 10'd0 : 10'($urandom_range(100));
        prev_pressure = s.pressure;
        return s;
    endfunction

    task automatic add_sample(input int p, input int pk, input int pp);
        sample_t s;
        s.pressure = 16'(p);
        s.peak     = 10'(pk);
        s.peep     = 10'(pp);
        samples_pending.push_back(s);
    endtask

    // The register is only written with nothing in flight.
    task automatic write_orientation(input logic value);
        @(posedge clk);
        cfg_write   <= 1'b1;
        cfg_data    <= value;
        orientation = value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (samples_pending.size() != 0 || in_valid || draw_cmds_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Request driver: predicts on acceptance, holds the payload while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                compute_draw_cmds(offered);
            if (!in_valid || !in_stall)
            begin
                if (samples_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    offered    = samples_pending.pop_front();
                    pressure   <= offered.pressure;
                    peak_level <= offered.peak;
                    peep_level <= offered.peep;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Command monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (draw_cmds_due.size() == 0)
                begin
                    $display("%0t: unexpected command, expected none, actual op %0d row %0d",
                             $time, op, row);
                    mismatch_count++;
                end
                else
                begin
                    oldest_due = draw_cmds_due.pop_front();
                    check_field("op", oldest_due.cmd.op, op);
                    check_field("row", oldest_due.cmd.row, row);
                    check_field("column", oldest_due.cmd.column, column);
                    check_field("height", oldest_due.cmd.height, height);
                    check_field("span", oldest_due.cmd.span, span);
                    check_field("ink", oldest_due.cmd.ink, ink);
                    check_field("last", oldest_due.last, last);
                end
            end
            out_stall <= holding || ($urandom_range(99) < snk_stall_pct);
        end
    end

    // Long receiver hold-off, counted from the start of its phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (holding)
            hold_cnt <= hold_cnt + 1;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d commands outstanding", $time,
                     draw_cmds_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int ph;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Vertical corners: wipe only, zero-result sample, zero-extent box,
        // saturation, unchanged fill, fall to zero, markers around the fill.
        write_orientation(ORIENT_VERT);
        add_sample(0, 0, 0);
        add_sample(1, 0, 0);
        add_sample(5, 1, 1);
        add_sample(32767, 1023, 1023);
        add_sample(949, 95, 96);
        add_sample(949, 95, 96);
        add_sample(-1, 0, 1);
        add_sample(-32768, 50, 10);
        add_sample(500, 40, 60);
        add_sample(250, 1, 0);
        drain();

        // Horizontal corners, including the switch that wipes the interior.
        write_orientation(ORIENT_HORIZ);
        add_sample(0, 0, 0);
        add_sample(2, 0, 0);
        add_sample(3, 1, 0);
        add_sample(900, 90, 91);
        add_sample(899, 89, 0);
        add_sample(32767, 1023, 1023);
        add_sample(-5, 0, 0);
        add_sample(450, 30, 45);
        add_sample(450, 30, 45);
        add_sample(1, 0, 1);
        drain();

        // Random phases over both orientations and all idling patterns.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_orientation(ORIENT_PLAN[ph]);
            src_idle_pct  = (ph % 4 == 1) ? 49 : (ph % 4 == 3) ? 17 : 0;
            snk_stall_pct = (ph % 4 == 2) ? 49 : (ph % 4 == 3) ? 17 : 0;
            hold_phase    = (ph == 0);
            repeat (PHASE_SAMPLES) samples_pending.push_back(gen_sample());
            drain();
            hold_phase = 1'b0;
        end

        if (draw_cmds_due.size() != 0)
        begin
            $display("%0t: %0d expected commands never arrived", $time, draw_cmds_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_scale.sv
hw/rtl/bgd_build.sv
hw/rtl/incremental_bargraph_draw_core.sv
hw/rtl/bgd_checker.sv
bench/incremental_bargraph_draw_core_tb.sv
